// ----- rtl/servo_bus_ping_transaction_core_macros.svh -----
// ---------------------------------------------------------------------------
// Servo bus ping transaction core: assertion macros
// Shared concurrent assertion forms, clocked on clk, off while rst_n is low.
// ---------------------------------------------------------------------------
`ifndef SERVO_BUS_PING_TRANSACTION_CORE_MACROS_SVH
`define SERVO_BUS_PING_TRANSACTION_CORE_MACROS_SVH

// Same-cycle implication
`define SBP_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) else $error(msg);

// Next-cycle implication
`define SBP_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);

`endif

// ----- rtl/sbping_pkg.sv -----
// ---------------------------------------------------------------------------
// sbping_pkg
// Types and constants shared by the servo bus ping transaction modules.
// ---------------------------------------------------------------------------
package sbping_pkg;

  // Tick timer width and configuration widths
  localparam int TIMER_W = 16;
  localparam int TO_W    = 16;
  localparam int RETRY_W = 3;
  localparam int CMP_W   = (TIMER_W > TO_W) ? TIMER_W : TO_W;

  // Configuration register indexes
  localparam logic [1:0] CFG_TIMEOUT = 2'd0;
  localparam logic [1:0] CFG_RETRY   = 2'd1;

  // Request opcodes
  localparam logic [1:0] OP_START = 2'd0;
  localparam logic [1:0] OP_BYTE  = 2'd1;
  localparam logic [1:0] OP_TICK  = 2'd2;

  // Frame constants
  localparam logic [7:0] HDR_BYTE   = 8'hFF;
  localparam logic [7:0] PING_LEN   = 8'h02;
  localparam logic [7:0] PING_INSTR = 8'h01;
  localparam int         FRAME_LEN  = 6;
  localparam logic [2:0] LAST_IDX   = 3'(FRAME_LEN - 1);

  // One buffered request
  typedef struct packed {
    logic [1:0] op;
    logic [7:0] sid;
    logic [7:0] rx;
  } item_t;

  // Load command from the controller to the frame serializer
  typedef struct packed {
    logic       load;
    logic       done;  // 1: finish result, 0: ping frame
    logic       ok;
    logic [7:0] id;
  } load_t;

  // Inverted 8-bit sum of three bytes
  function automatic logic [7:0] frame_sum(input logic [7:0] a, input logic [7:0] b,
                                           input logic [7:0] c);
    logic [7:0] s;
    s = a + b + c;
    return ~s;
  endfunction

endpackage

// ----- rtl/sbping_ctrl.sv -----
// ---------------------------------------------------------------------------
// sbping_ctrl
// Transaction state: target id, reply collection, tick timer and retries.
// ---------------------------------------------------------------------------
module sbping_ctrl (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          item_vld,
  input  sbping_pkg::item_t             item,
  input  logic                          tx_free,
  input  logic [sbping_pkg::TO_W-1:0]   timeout_ticks,
  input  logic [sbping_pkg::RETRY_W-1:0] retry_limit,
  output logic                          fire,
  output sbping_pkg::load_t             ld
);

  logic                            busy_r, busy_nxt;
  logic [7:0]                      tid_r, tid_nxt;
  logic [2:0]                      rc_r, rc_nxt;
  logic [sbping_pkg::TIMER_W-1:0]  el_r, el_nxt;
  logic [sbping_pkg::RETRY_W-1:0]  ts_r, ts_nxt;
  logic [7:0]                      rb_r [5];
  logic                            rb_we;

  logic [sbping_pkg::TIMER_W-1:0]  el_inc;
  logic [sbping_pkg::RETRY_W-1:0]  ts_inc;
  logic                            reply_ok;
  sbping_pkg::load_t               res;

  // Saturating timer step, timeout count step and reply check
  always_comb begin
    el_inc   = (el_r == '1) ? el_r : el_r + 1'b1;
    ts_inc   = ts_r + 1'b1;
    reply_ok = (rb_r[0] == sbping_pkg::HDR_BYTE) && (rb_r[1] == sbping_pkg::HDR_BYTE) &&
               (item.rx == sbping_pkg::frame_sum(rb_r[2], rb_r[3], rb_r[4]));
  end

  // Decide next state and the result burst for the buffered request
  always_comb begin
    busy_nxt = busy_r;
    tid_nxt  = tid_r;
    rc_nxt   = rc_r;
    el_nxt   = el_r;
    ts_nxt   = ts_r;
    rb_we    = 1'b0;
    res      = '0;
    if (item.op == sbping_pkg::OP_START) begin
      busy_nxt = 1'b1;
      tid_nxt  = item.sid;
      rc_nxt   = '0;
      el_nxt   = '0;
      ts_nxt   = '0;
      res.load = 1'b1;
      res.id   = item.sid;
    end else if (busy_r) begin
      unique case (item.op)
        sbping_pkg::OP_BYTE: begin
          if (rc_r != sbping_pkg::LAST_IDX) begin
            rb_we  = 1'b1;
            rc_nxt = rc_r + 1'b1;
          end else begin
            rc_nxt   = '0;
            res.load = 1'b1;
            res.id   = tid_r;
            if (reply_ok) begin
              busy_nxt = 1'b0;
              res.done = 1'b1;
              res.ok   = 1'b1;
            end
          end
        end
        sbping_pkg::OP_TICK: begin
          if (sbping_pkg::CMP_W'(el_inc) > sbping_pkg::CMP_W'(timeout_ticks)) begin
            el_nxt   = '0;
            rc_nxt   = '0;
            ts_nxt   = ts_inc;
            res.load = 1'b1;
            res.id   = tid_r;
            if (ts_inc >= retry_limit) begin
              busy_nxt = 1'b0;
              res.done = 1'b1;
            end
          end else begin
            el_nxt = el_inc;
          end
        end
        default: begin
        end
      endcase
    end
  end

  // Take the request when it needs no output or the serializer is free
  assign fire    = item_vld && (!res.load || tx_free);
  assign ld      = '{load: fire && res.load, done: res.done, ok: res.ok, id: res.id};

  // Control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      tid_r  <= '0;
      rc_r   <= '0;
      el_r   <= '0;
      ts_r   <= '0;
    end else if (fire) begin
      busy_r <= busy_nxt;
      tid_r  <= tid_nxt;
      rc_r   <= rc_nxt;
      el_r   <= el_nxt;
      ts_r   <= ts_nxt;
    end
  end

  // Reply byte store, no reset
  always_ff @(posedge clk) begin
    if (fire && rb_we) begin
      rb_r[rc_r] <= item.rx;
    end
  end

endmodule

// ----- rtl/sbping_tx.sv -----
// ---------------------------------------------------------------------------
// sbping_tx
// Result serializer: plays out a six-byte ping frame or one finish result.
// ---------------------------------------------------------------------------
module sbping_tx (
  input  logic              clk,
  input  logic              rst_n,
  input  sbping_pkg::load_t ld,
  output logic              tx_free,
  output logic              out_tvalid,
  input  logic              out_tready,
  output logic [15:0]       out_tdata,   // [7:0] tx_byte, [8] success, [15:9] zero
  output logic              out_tuser,   // [0] kind
  output logic              out_tlast
);

  logic       act_r;
  logic [2:0] idx_r;
  logic       done_r;
  logic       ok_r;
  logic [7:0] id_r;
  logic [7:0] ck_r;
  logic [7:0] byte_c;
  logic       final_c;

  // Select the frame byte for the current position
  always_comb begin
    unique case (idx_r)
      3'd0, 3'd1: byte_c = sbping_pkg::HDR_BYTE;
      3'd2:       byte_c = id_r;
      3'd3:       byte_c = sbping_pkg::PING_LEN;
      3'd4:       byte_c = sbping_pkg::PING_INSTR;
      default:    byte_c = ck_r;
    endcase
  end

  assign final_c    = done_r || (idx_r == sbping_pkg::LAST_IDX);
  assign tx_free    = !act_r || (out_tready && final_c);
  assign out_tvalid = act_r;
  assign out_tuser  = done_r;
  assign out_tlast  = !done_r && (idx_r == sbping_pkg::LAST_IDX);
  assign out_tdata  = {7'd0, done_r & ok_r, done_r ? 8'd0 : byte_c};

  // Burst control: load wins, else advance on each taken result
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      act_r <= 1'b0;
      idx_r <= '0;
    end else if (ld.load) begin
      act_r <= 1'b1;
      idx_r <= '0;
    end else if (act_r && out_tready) begin
      if (final_c) begin
        act_r <= 1'b0;
      end else begin
        idx_r <= idx_r + 1'b1;
      end
    end
  end

  // Burst payload
  always_ff @(posedge clk) begin
    if (ld.load) begin
      done_r <= ld.done;
      ok_r   <= ld.ok;
      id_r   <= ld.id;
      ck_r   <= sbping_pkg::frame_sum(ld.id, sbping_pkg::PING_LEN, sbping_pkg::PING_INSTR);
    end
  end

endmodule

// ----- rtl/servo_bus_ping_transaction_core.sv -----
// ---------------------------------------------------------------------------
// servo_bus_ping_transaction_core
// Servo bus ping: sends FF FF id 02 01 cks, checks the reply, retries on
// timeout and reports success or failure.
// ---------------------------------------------------------------------------
// A request enters an input register and is decided from there, so
// requests that make no output (received bytes, ticks) go at one per cycle.
// A request that sends a ping holds the single result serializer for the
// six frame bytes, one byte per cycle while the receiver is ready.
// A new request is taken while the serializer still drains, and a request
// that makes output waits only for the serializer's last result to leave.
// Configuration writes are always accepted and take effect the next cycle.
module servo_bus_ping_transaction_core (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [15:0] in_tdata,    // [7:0] servo_id, [15:8] rx_byte
  input  logic [1:0]  in_tuser,    // [1:0] opcode
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [15:0] out_tdata,   // [7:0] tx_byte, [8] success, [15:9] zero
  output logic        out_tuser,   // [0] kind
  output logic        out_tlast,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [1:0]  cfg_addr,
  input  logic [15:0] cfg_data
);

`include "servo_bus_ping_transaction_core_macros.svh"

  logic                             in_vld_r;
  sbping_pkg::item_t                item_r;
  logic                             fire;
  logic                             tx_free;
  sbping_pkg::load_t                ld;
  logic [sbping_pkg::TO_W-1:0]      timeout_r;
  logic [sbping_pkg::RETRY_W-1:0]   retry_r;

  // Configuration registers
  assign cfg_ready = 1'b1;
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      timeout_r <= sbping_pkg::TO_W'(5);
      retry_r   <= sbping_pkg::RETRY_W'(5);
    end else if (cfg_valid) begin
      if (cfg_addr == sbping_pkg::CFG_TIMEOUT) begin
        timeout_r <= cfg_data[sbping_pkg::TO_W-1:0];
      end else if (cfg_addr == sbping_pkg::CFG_RETRY) begin
        retry_r <= cfg_data[sbping_pkg::RETRY_W-1:0];
      end
    end
  end

  // Input register: refill when empty or when the held request is taken
  assign in_tready = !in_vld_r || fire;
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_vld_r <= 1'b0;
    end else if (in_tready) begin
      in_vld_r <= in_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_tvalid && in_tready) begin
      item_r <= '{op: in_tuser, sid: in_tdata[7:0], rx: in_tdata[15:8]};
    end
  end

  sbping_ctrl u_ctrl (
    .clk           (clk),
    .rst_n         (rst_n),
    .item_vld      (in_vld_r),
    .item          (item_r),
    .tx_free       (tx_free),
    .timeout_ticks (timeout_r),
    .retry_limit   (retry_r),
    .fire          (fire),
    .ld            (ld)
  );

  sbping_tx u_tx (
    .clk        (clk),
    .rst_n      (rst_n),
    .ld         (ld),
    .tx_free    (tx_free),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .out_tlast  (out_tlast)
  );

  // A burst is loaded only into a free serializer
  `SBP_ASSERT_NOW(a_load_free, ld.load, tx_free, "burst loaded over pending results")
  // A finish result never carries the frame end mark
  `SBP_ASSERT_NOW(a_done_nolast, out_tvalid && out_tuser, !out_tlast && (out_tdata[7:0] == 8'd0), "finish result with frame fields")
  // A loaded burst shows up at the output next cycle
  `SBP_ASSERT_NEXT(a_load_shows, ld.load, out_tvalid && (out_tuser == $past(ld.done)), "loaded burst not presented")

endmodule

// ----- verif/servo_bus_ping_transaction_core_test.sv -----
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// servo_bus_ping_transaction_core_test
// Self-checking bench for the servo bus ping core. A short directed run
// covers the idle cases, a good reply, a bad reply, a restart and a timeout.
// Random transactions then run under several register settings, with bursty
// requests and a stalling receiver. Every accepted request goes through a
// local transaction model, and each result is compared field by field.
// ---------------------------------------------------------------------------

// Opcode with no meaning for the core
localparam logic [1:0] OP_NOP = 2'd3;

typedef struct {
  bit         kind;
  logic [7:0] tx_byte;
  bit         last;
  bit         success;
} ping_result_t;

// Transaction model plus the queue of results it predicts
class ping_scoreboard;
  logic [15:0]  timeout_ticks;
  logic [2:0]   retry_limit;
  bit           busy;
  logic [7:0]   target_id;
  logic [7:0]   reply_bytes [6];
  int unsigned  reply_count;
  logic [15:0]  elapsed;
  logic [2:0]   timeouts_seen;
  ping_result_t expected_q [$];
  int unsigned  errors;
  int unsigned  checked;
  int unsigned  starts;
  int unsigned  n_success;
  int unsigned  n_fail;

  function new();
    timeout_ticks = 16'd5;
    retry_limit   = 3'd5;
    busy          = 1'b0;
    target_id     = 8'd0;
    reply_count   = 0;
    elapsed       = 16'd0;
    timeouts_seen = 3'd0;
    errors        = 0;
    checked       = 0;
    starts        = 0;
    n_success     = 0;
    n_fail        = 0;
  endfunction

  function logic [7:0] inv_sum(logic [7:0] a, logic [7:0] b, logic [7:0] c);
    logic [7:0] s;
    s = a + b + c;
    return ~s;
  endfunction

  function void queue_ping();
    logic [7:0]   frame [6];
    ping_result_t r;
    frame[0] = sbping_pkg::HDR_BYTE;
    frame[1] = sbping_pkg::HDR_BYTE;
    frame[2] = target_id;
    frame[3] = sbping_pkg::PING_LEN;
    frame[4] = sbping_pkg::PING_INSTR;
    frame[5] = inv_sum(target_id, sbping_pkg::PING_LEN, sbping_pkg::PING_INSTR);
    for (int i = 0; i < 6; i++) begin
      r.kind    = 1'b0;
      r.tx_byte = frame[i];
      r.last    = (i == 5);
      r.success = 1'b0;
      expected_q.push_back(r);
    end
  endfunction

  function void queue_finish(bit ok);
    ping_result_t r;
    r.kind    = 1'b1;
    r.tx_byte = 8'd0;
    r.last    = 1'b0;
    r.success = ok;
    expected_q.push_back(r);
    if (ok) n_success++;
    else n_fail++;
  endfunction

  function void write_reg(logic [1:0] idx, logic [15:0] val);
    case (idx)
      sbping_pkg::CFG_TIMEOUT: timeout_ticks = val;
      sbping_pkg::CFG_RETRY:   retry_limit = val[2:0];
      default: ;
    endcase
  endfunction

  // Advance the model by one accepted request
  function void note_request(logic [1:0] op, logic [7:0] sid, logic [7:0] rx);
    case (op)
      sbping_pkg::OP_START: begin
        starts++;
        busy          = 1'b1;
        target_id     = sid;
        reply_count   = 0;
        elapsed       = 16'd0;
        timeouts_seen = 3'd0;
        queue_ping();
      end
      sbping_pkg::OP_BYTE: begin
        if (busy) begin
          reply_bytes[reply_count] = rx;
          reply_count++;
          if (reply_count == 6) begin
            reply_count = 0;
            if (reply_bytes[0] == sbping_pkg::HDR_BYTE &&
                reply_bytes[1] == sbping_pkg::HDR_BYTE &&
                reply_bytes[5] == inv_sum(reply_bytes[2], reply_bytes[3], reply_bytes[4]))
            begin
              busy = 1'b0;
              queue_finish(1'b1);
            end else begin
              queue_ping();
            end
          end
        end
      end
      sbping_pkg::OP_TICK: begin
        if (busy) begin
          // saturate the timer at all ones
          if (elapsed != 16'hFFFF) elapsed++;
          if (elapsed > timeout_ticks) begin
            elapsed     = 16'd0;
            reply_count = 0;
            timeouts_seen++;
            if (timeouts_seen >= retry_limit) begin
              busy = 1'b0;
              queue_finish(1'b0);
            end else begin
              queue_ping();
            end
          end
        end
      end
      default: ;
    endcase
  endfunction

  // Compare one result with the oldest prediction
  function void check_result(bit kind, logic [7:0] tx, bit last, bit ok, logic [6:0] pad);
    ping_result_t r;
    checked++;
    if (expected_q.size() == 0) begin
      $error("unexpected result: kind %0d tx_byte %02h last %0d success %0d",
             kind, tx, last, ok);
      errors++;
      return;
    end
    r = expected_q.pop_front();
    if (kind !== r.kind) begin
      $error("kind: expected %0d, actual %0d", r.kind, kind);
      errors++;
    end
    if (tx !== r.tx_byte) begin
      $error("tx_byte: expected %02h, actual %02h", r.tx_byte, tx);
      errors++;
    end
    if (last !== r.last) begin
      $error("last: expected %0d, actual %0d", r.last, last);
      errors++;
    end
    if (ok !== r.success) begin
      $error("success: expected %0d, actual %0d", r.success, ok);
      errors++;
    end
    if (pad !== 7'd0) begin
      $error("tdata_pad: expected 0, actual %02h", pad);
      errors++;
    end
  endfunction

  function int pending();
    return expected_q.size();
  endfunction
endclass

module servo_bus_ping_transaction_core_test;

  localparam longint CYCLE_LIMIT = 1000000;
  localparam int     SETTLE      = 16;
  localparam int     HOLD_CYCLES = 300;

  logic        clk        = 1'b0;
  logic        rst_n      = 1'b0;
  logic        in_tvalid  = 1'b0;
  logic [15:0] in_tdata   = 16'd0;
  logic [1:0]  in_tuser   = 2'd0;
  logic        out_tready = 1'b0;
  logic        cfg_valid  = 1'b0;
  logic [1:0]  cfg_addr   = 2'd0;
  logic [15:0] cfg_data   = 16'd0;
  logic        in_tready;
  logic        out_tvalid;
  logic [15:0] out_tdata;
  logic        out_tuser;
  logic        out_tlast;
  logic        cfg_ready;

  ping_scoreboard sb;
  longint         cycles    = 0;
  int             sent      = 0;
  int             gap_max   = 0;
  int             burst_left = 0;
  int             stall_mode = 0;
  bit             hold_req  = 1'b0;
  int             hold_left = 0;

  servo_bus_ping_transaction_core uut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .out_tlast  (out_tlast),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_addr   (cfg_addr),
    .cfg_data   (cfg_data)
  );

  always #1 clk = ~clk;

  // Bound the run
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles >= CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d results outstanding", cycles, sb.pending());
      $display("** servo_bus_ping_transaction_core: FAILED **");
      $finish;
    end
  end

  // Check results and drive the receiver's stall pattern
  always @(posedge clk) begin
    if (rst_n && out_tvalid && out_tready)
      sb.check_result(out_tuser, out_tdata[7:0], out_tlast, out_tdata[8], out_tdata[15:9]);
    if (hold_req) begin
      hold_req  = 1'b0;
      hold_left = HOLD_CYCLES;
    end
    if (hold_left > 0) begin
      hold_left--;
      out_tready <= 1'b0;
    end else begin
      case (stall_mode)
        0: out_tready <= 1'b1;
        1: out_tready <= 1'($urandom_range(0, 1));
        2: out_tready <= ((cycles % 7) < 4);
        default: out_tready <= ($urandom_range(0, 3) == 0);
      endcase
    end
  end

  // Offer one request, in bursts with random gaps between them
  task automatic send_request(input logic [1:0] op, input logic [7:0] sid,
                              input logic [7:0] rx);
    int gap;
    if (gap_max > 0 && burst_left == 0) begin
      gap = $urandom_range(1, gap_max);
      in_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
      burst_left = $urandom_range(1, 12);
    end
    if (burst_left > 0) burst_left--;
    in_tvalid <= 1'b1;
    in_tuser  <= op;
    in_tdata  <= {rx, sid};
    do @(posedge clk); while (!in_tready);
    sb.note_request(op, sid, rx);
    sent++;
  endtask

  task automatic send_tick();
    send_request(sbping_pkg::OP_TICK, 8'($urandom), 8'($urandom));
  endtask

  task automatic send_start();
    send_request(sbping_pkg::OP_START, 8'($urandom), 8'($urandom));
  endtask

  // Hold off until every predicted result has left and the core has settled
  task automatic wait_idle();
    in_tvalid <= 1'b0;
    while (sb.pending() != 0) @(posedge clk);
    repeat (SETTLE) @(posedge clk);
  endtask

  task automatic write_cfg(input logic [1:0] idx, input logic [15:0] val);
    cfg_valid <= 1'b1;
    cfg_addr  <= idx;
    cfg_data  <= val;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    sb.write_reg(idx, val);
  endtask

  task automatic configure(input logic [15:0] to_ticks, input logic [2:0] retries);
    wait_idle();
    write_cfg(sbping_pkg::CFG_TIMEOUT, to_ticks);
    write_cfg(sbping_pkg::CFG_RETRY, {13'd0, retries});
  endtask

  task automatic set_pace(input int gaps, input int stalls);
    gap_max    = gaps;
    burst_left = 0;
    stall_mode = stalls;
  endtask

  // Send a six-byte reply, optionally corrupted, with ticks mixed in
  task automatic send_reply(input bit good, input int ticks_max);
    logic [7:0] f [6];
    logic [7:0] s;
    int         idx;
    f[0] = sbping_pkg::HDR_BYTE;
    f[1] = sbping_pkg::HDR_BYTE;
    f[2] = 8'($urandom);
    f[3] = 8'($urandom);
    f[4] = 8'($urandom);
    s    = f[2] + f[3] + f[4];
    f[5] = ~s;
    if (!good) begin
      idx = $urandom_range(0, 5);
      f[idx] = f[idx] ^ 8'($urandom_range(1, 255));
    end
    for (int k = 0; k < 6; k++) begin
      repeat ($urandom_range(0, ticks_max)) send_tick();
      send_request(sbping_pkg::OP_BYTE, 8'($urandom), f[k]);
    end
  endtask

  // Ticks enough to walk through most of the retries at this setting
  function automatic int tick_budget();
    int b;
    b = (int'(sb.timeout_ticks) + 1) * (int'(sb.retry_limit) + 1) + 2;
    return (b > 40) ? 40 : b;
  endfunction

  // Random transactions: mostly well-formed, some broken, some noise
  task automatic run_transactions(input int n);
    int base;
    int pick;
    base = sent;
    while (sent - base < n) begin
      pick = $urandom_range(0, 9);
      if (pick <= 4) begin
        send_start();
        send_reply(pick < 4, (pick == 2) ? 2 : 0);
      end else if (pick <= 6) begin
        send_start();
        repeat ($urandom_range(1, tick_budget())) send_tick();
      end else if (pick == 7) begin
        send_start();
        repeat ($urandom_range(1, 5))
          send_request(sbping_pkg::OP_BYTE, 8'($urandom), 8'($urandom));
      end else if (pick == 8) begin
        repeat ($urandom_range(1, 4))
          send_request(2'($urandom_range(0, 3)), 8'($urandom), 8'($urandom));
      end else begin
        send_reply(1'($urandom_range(0, 1)), 1);
      end
    end
  endtask

  initial begin
    logic [7:0] good_reply [6];
    logic [7:0] bad_reply [6];
    good_reply = '{8'hFF, 8'hFF, 8'h00, 8'h00, 8'h00, 8'hFF};
    bad_reply  = '{8'hFF, 8'hFF, 8'h12, 8'h34, 8'h56, 8'h00};
    sb = new();
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed: idle items, good reply, bad reply, restart, timeout
    set_pace(3, 1);
    send_request(sbping_pkg::OP_BYTE, 8'h00, 8'hFF);
    send_request(sbping_pkg::OP_TICK, 8'hFF, 8'h00);
    send_request(OP_NOP, 8'hAA, 8'h55);
    send_request(sbping_pkg::OP_START, 8'h00, 8'hFF);
    for (int k = 0; k < 6; k++) send_request(sbping_pkg::OP_BYTE, 8'hFF, good_reply[k]);
    send_request(sbping_pkg::OP_START, 8'hFF, 8'h00);
    for (int k = 0; k < 6; k++) send_request(sbping_pkg::OP_BYTE, 8'h00, bad_reply[k]);
    send_request(OP_NOP, 8'h55, 8'hAA);
    send_request(sbping_pkg::OP_START, 8'hA5, 8'h5A);
    repeat (6) send_tick();

    // Zero retries and zero timeout: the first tick gives up
    configure(16'd0, 3'd0);
    send_request(sbping_pkg::OP_START, 8'h5A, 8'hA5);
    send_tick();

    // Timeout of one tick, single retry
    configure(16'd1, 3'd1);
    set_pace(4, 2);
    run_transactions(85);

    // Longest timeout, most retries, no idling on either side
    configure(16'hFFFF, 3'd7);
    set_pace(0, 0);
    run_transactions(60);

    // Mid settings; long receiver hold-off fills the core first
    configure(16'($urandom_range(2, 12)), 3'($urandom_range(1, 7)));
    set_pace(6, 3);
    hold_req = 1'b1;
    repeat (10) send_start();
    run_transactions(85);

    // Short timeout with the count running up to seven
    configure(16'd3, 3'd7);
    set_pace(2, 1);
    run_transactions(85);

    // Longest timeout: a run of ticks never times out before the reply
    configure(16'hFFFF, 3'd1);
    set_pace(0, 0);
    send_start();
    repeat (8) send_tick();
    send_reply(1'b1, 0);

    wait_idle();
    $display("covered %0d requests, %0d ping starts, %0d results checked",
             sent, sb.starts, sb.checked);
    $display("transactions ended: %0d with a valid reply, %0d after retries ran out",
             sb.n_success, sb.n_fail);
    if (sb.errors == 0 && sb.pending() == 0) begin
      $display("** servo_bus_ping_transaction_core: PASSED **");
    end else begin
      $display("** servo_bus_ping_transaction_core: FAILED **");
    end
    $finish;
  end

endmodule
